// ----- hw/rtl/apu_pkg.sv -----
package apu_pkg;

  // line buffer size and derived index width
  localparam int MAX_WIDTH = 4096;
  localparam int COL_W     = $clog2(MAX_WIDTH);

  // configuration register widths
  localparam int CFG_WIDTH_W  = 13;
  localparam int CFG_HEIGHT_W = 15;
  localparam int PADDR_W      = 4;
  localparam int PDATA_W      = 32;

  // stream word widths
  localparam int ALPHA_W = 8;
  localparam int RGB_W   = 24;
  localparam int TDATA_W = ALPHA_W + RGB_W;

  // front to back queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // register index codes
  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MODE   = 2'd2
  } cfg_reg_e;

  // predictor codes
  typedef enum logic [1:0] {
    MODE_NONE       = 2'd0,
    MODE_HORIZONTAL = 2'd1,
    MODE_VERTICAL   = 2'd2,
    MODE_GRADIENT   = 2'd3
  } filter_mode_e;

  // one classified pixel on its way to the back end
  typedef struct packed {
    logic [COL_W-1:0]   col;
    logic               first_row;
    logic               first_col;
    logic               last;
    logic [ALPHA_W-1:0] residual;
    logic [RGB_W-1:0]   rgb;
  } pix_cmd_t;

endpackage

// ----- hw/rtl/apu_ram.sv -----
module apu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port (old data on collision)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/apu_front.sv -----
module apu_front
  import apu_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    restart_i,
  input  logic [CFG_WIDTH_W-1:0]  image_width_i,
  input  logic [CFG_HEIGHT_W-1:0] image_height_i,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  logic [TDATA_W-1:0]      s_axis_tdata_i,
  input  logic                    q_ready_i,
  output logic                    q_push_o,
  output pix_cmd_t                q_cmd_o
);

  localparam int XW = (COL_W + 1 > CFG_WIDTH_W) ? COL_W + 1 : CFG_WIDTH_W;
  localparam int YW = CFG_HEIGHT_W + 1;

  logic [COL_W-1:0]        col_q, col_d;
  logic [CFG_HEIGHT_W-1:0] row_q, row_d;
  logic [XW-1:0]           width_ext, width_eff, col_next;
  logic [YW-1:0]           height_eff, row_next;
  logic                    col_end, row_end, accept;

  // effective frame size: zero acts as one, width capped at the line buffer
  always_comb begin
    width_ext = XW'(image_width_i);
    if (width_ext == '0) begin
      width_eff = XW'(1);
    end else if (width_ext > XW'(MAX_WIDTH)) begin
      width_eff = XW'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    if (image_height_i == '0) begin
      height_eff = YW'(1);
    end else begin
      height_eff = YW'(image_height_i);
    end
  end

  // position classification
  assign col_next = XW'(col_q) + XW'(1);
  assign row_next = YW'(row_q) + YW'(1);
  assign col_end  = (col_next >= width_eff);
  assign row_end  = (row_next >= height_eff);

  assign s_axis_tready_o = q_ready_i;
  assign accept          = s_axis_tvalid_i && q_ready_i;
  assign q_push_o        = accept;

  always_comb begin
    q_cmd_o.col       = col_q;
    q_cmd_o.first_row = (row_q == '0);
    q_cmd_o.first_col = (col_q == '0);
    q_cmd_o.last      = col_end && row_end;
    q_cmd_o.residual  = s_axis_tdata_i[ALPHA_W-1:0];
    q_cmd_o.rgb       = s_axis_tdata_i[TDATA_W-1:ALPHA_W];
  end

  // scan position of the next word
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : CFG_HEIGHT_W'(row_next);
      end else begin
        col_d = COL_W'(col_next);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ----- hw/rtl/apu_queue.sv -----
module apu_queue
  import apu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  pix_cmd_t push_cmd_i,
  output logic     ready_o,
  input  logic     pop_i,
  output logic     valid_o,
  output pix_cmd_t head_o
);

  pix_cmd_t            mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0]  cnt_q;

  assign ready_o = (cnt_q != Q_CNT_W'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + Q_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - Q_CNT_W'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/apu_back.sv -----
module apu_back
  import apu_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               restart_i,
  input  filter_mode_e       filter_mode_i,
  input  logic               q_valid_i,
  input  pix_cmd_t           q_head_i,
  output logic               q_pop_o,
  output logic               ram_re_o,
  output logic [COL_W-1:0]   ram_raddr_o,
  input  logic [ALPHA_W-1:0] ram_rdata_i,
  output logic               ram_we_o,
  output logic [COL_W-1:0]   ram_waddr_o,
  output logic [ALPHA_W-1:0] ram_wdata_o,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [TDATA_W-1:0] m_axis_tdata_o,
  output logic               m_axis_tlast_o
);

  pix_cmd_t           work_q;
  logic               work_valid_q;
  logic               above_live_q;
  logic [ALPHA_W-1:0] above_q;
  logic [ALPHA_W-1:0] left_q, upper_left_q;
  logic               out_valid_q;
  logic [TDATA_W-1:0] out_data_q;
  logic               out_last_q;

  logic               fire, pop, collide;
  logic [ALPHA_W-1:0] above, pred, alpha;
  logic [ALPHA_W+1:0] grad_sum;

  // handshakes between queue, work stage and output register
  assign fire    = work_valid_q && (!out_valid_q || m_axis_tready_i);
  assign pop     = q_valid_i && (!work_valid_q || fire);
  assign collide = fire && pop && (work_q.col == q_head_i.col);
  assign q_pop_o = pop;

  // line buffer read for the word entering the work stage
  assign ram_re_o    = pop;
  assign ram_raddr_o = q_head_i.col;

  // above value: fresh read data, held copy, or forwarded write
  assign above = above_live_q ? ram_rdata_i : above_q;

  // gradient: left + above - upper left, clipped to a byte
  assign grad_sum = {2'b00, left_q} + {2'b00, above} - {2'b00, upper_left_q};

  // predictor selection
  always_comb begin
    if (filter_mode_i == MODE_NONE || (work_q.first_row && work_q.first_col)) begin
      pred = '0;
    end else if (work_q.first_row) begin
      pred = left_q;
    end else if (work_q.first_col) begin
      pred = above;
    end else begin
      case (filter_mode_i)
        MODE_HORIZONTAL: pred = left_q;
        MODE_VERTICAL:   pred = above;
        MODE_GRADIENT: begin
          if (grad_sum[ALPHA_W+1]) begin
            pred = '0;
          end else if (grad_sum[ALPHA_W]) begin
            pred = '1;
          end else begin
            pred = grad_sum[ALPHA_W-1:0];
          end
        end
        default: pred = '0;
      endcase
    end
  end

  assign alpha = work_q.residual + pred;

  // line buffer write-back
  assign ram_we_o    = fire;
  assign ram_waddr_o = work_q.col;
  assign ram_wdata_o = alpha;

  // work stage payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      work_q <= q_head_i;
    end
    if (pop && collide) begin
      above_q <= alpha;
    end else if (work_valid_q && !fire && above_live_q) begin
      above_q <= ram_rdata_i;
    end
    if (fire) begin
      out_data_q <= {alpha, work_q.rgb};
      out_last_q <= work_q.last;
    end
  end

  // control and neighbor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_valid_q <= 1'b0;
      above_live_q <= 1'b0;
      out_valid_q  <= 1'b0;
      left_q       <= '0;
      upper_left_q <= '0;
    end else begin
      if (pop) begin
        work_valid_q <= 1'b1;
        above_live_q <= !collide;
      end else begin
        if (fire) begin
          work_valid_q <= 1'b0;
        end
        if (work_valid_q && !fire) begin
          above_live_q <= 1'b0;
        end
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (restart_i) begin
        left_q       <= '0;
        upper_left_q <= '0;
      end else if (fire) begin
        left_q       <= work_q.last ? '0 : alpha;
        upper_left_q <= work_q.last ? '0 : above;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ----- hw/rtl/alpha_plane_unfilter.sv -----
// channel    | dir | handshake                 | payload
// apb config | in  | psel/penable/pwrite/pready | paddr, pwdata, prdata
// s_axis     | in  | tvalid/tready             | tdata
// m_axis     | out | tvalid/tready             | tdata, tlast
//
// one pixel per clock sustained while m_axis_tready_i stays high; a word
// accepted on s_axis is written into the queue, then moves to the work
// stage together with its line buffer read, then loads the output register
// that drives m_axis_tvalid_o
// the 4096 x 8 line buffer has one read and one write port; a read that
// hits the address being written is served by forwarding
// reset clears positions, neighbor bytes and all valid flags; the line
// buffer is not cleared and needs no sweep
// a stall on m_axis fills the output register, work stage and two-entry
// queue before s_axis_tready_o drops
module alpha_plane_unfilter
  import apu_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // filtered_alpha [7:0], color_rgb [31:8]
  input  logic [TDATA_W-1:0] s_axis_tdata_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // pixel_argb [31:0]
  output logic [TDATA_W-1:0] m_axis_tdata_o,
  output logic               m_axis_tlast_o
);

  logic [CFG_WIDTH_W-1:0]  image_width_q;
  logic [CFG_HEIGHT_W-1:0] image_height_q;
  filter_mode_e            filter_mode_q;
  cfg_reg_e                reg_idx;
  logic                    cfg_wr, restart;

  logic                    q_push, q_ready, q_pop, q_valid;
  pix_cmd_t                q_cmd, q_head;

  logic                    ram_re, ram_we;
  logic [COL_W-1:0]        ram_raddr, ram_waddr;
  logic [ALPHA_W-1:0]      ram_rdata, ram_wdata;

  // register decode
  assign pready  = 1'b1;
  assign reg_idx = cfg_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_WIDTH:  restart = cfg_wr;
      REG_HEIGHT: restart = cfg_wr;
      REG_MODE:   restart = cfg_wr;
      default:    restart = 1'b0;
    endcase
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH:  prdata = PDATA_W'(image_width_q);
      REG_HEIGHT: prdata = PDATA_W'(image_height_q);
      REG_MODE:   prdata = PDATA_W'(filter_mode_q);
      default:    prdata = '0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= CFG_WIDTH_W'(1);
      image_height_q <= CFG_HEIGHT_W'(1);
      filter_mode_q  <= MODE_NONE;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_WIDTH:  image_width_q  <= pwdata[CFG_WIDTH_W-1:0];
        REG_HEIGHT: image_height_q <= pwdata[CFG_HEIGHT_W-1:0];
        REG_MODE:   filter_mode_q  <= filter_mode_e'(pwdata[1:0]);
        default: ;
      endcase
    end
  end

  apu_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .restart_i       (restart),
    .image_width_i   (image_width_q),
    .image_height_i  (image_height_q),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .q_ready_i       (q_ready),
    .q_push_o        (q_push),
    .q_cmd_o         (q_cmd)
  );

  apu_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_cmd),
    .ready_o    (q_ready),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  apu_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .restart_i       (restart),
    .filter_mode_i   (filter_mode_q),
    .q_valid_i       (q_valid),
    .q_head_i        (q_head),
    .q_pop_o         (q_pop),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  apu_ram #(
    .WIDTH (ALPHA_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // the queue is only written when it has room
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> q_ready)
    else $error("queue written while full");

  // a pop needs a stored entry
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // every line buffer write-back loads the output register
  a_wb_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> m_axis_tvalid_o)
    else $error("write-back without output word");

  // a line buffer read only comes together with a pop
  a_read_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> q_pop)
    else $error("line buffer read without pop");

endmodule

// ----- tb/alpha_plane_unfilter_tb.sv -----
module alpha_plane_unfilter_tb;
  import apu_pkg::*;

  localparam int                 HALF_PERIOD  = 10;
  localparam int                 RESET_CYCLES = 4;
  localparam int                 RANDOM_ITEMS = 960;
  localparam int                 STALL_LIMIT  = 4000;
  localparam int                 DRAIN_CYCLES = 10;
  localparam int                 PHASE_CAP    = 150;
  localparam int                 CLAMP_RUN    = 40;
  localparam int                 HEIGHT_MAX   = 16384;
  localparam int                 ALPHA_MAX    = 255;
  // an address past the last register, writes there must be ignored
  localparam logic [PADDR_W-1:0] SPARE_ADDR   = 4'd12;

  typedef struct packed {
    logic [TDATA_W-1:0] argb;
    logic               last;
  } pixel_out_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               psel            = 1'b0;
  logic               penable         = 1'b0;
  logic               pwrite          = 1'b0;
  logic [PADDR_W-1:0] paddr           = '0;
  logic [PDATA_W-1:0] pwdata          = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  // filtered_alpha [7:0], color_rgb [31:8]
  logic [TDATA_W-1:0] s_axis_tdata_i  = '0;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  // pixel_argb [31:0]
  logic [TDATA_W-1:0] m_axis_tdata_o;
  logic               m_axis_tlast_o;

  alpha_plane_unfilter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // predictor copy of registers and scan state
  logic [CFG_WIDTH_W-1:0]  width_reg  = 1;
  logic [CFG_HEIGHT_W-1:0] height_reg = 1;
  filter_mode_e            mode_reg   = MODE_NONE;
  logic [ALPHA_W-1:0]      alpha_line [MAX_WIDTH];
  logic [ALPHA_W-1:0]      left_a     = '0;
  logic [ALPHA_W-1:0]      upleft_a   = '0;
  int unsigned             col_pos    = 0;
  int unsigned             row_pos    = 0;

  logic [TDATA_W-1:0] pixel_fifo [$];
  pixel_out_t         argb_expect [$];
  int                 err_count   = 0;
  int                 out_count   = 0;

  initial begin
    foreach (alpha_line[i]) alpha_line[i] = '0;
  end

  task automatic flag_mismatch(input string what);
    $display("error: %s", what);
    err_count++;
  endtask

  function automatic void restart_scan();
    left_a   = '0;
    upleft_a = '0;
    col_pos  = 0;
    row_pos  = 0;
  endfunction

  // rebuild alpha for one accepted word and queue the expected output
  function automatic void unfilter_pixel(input logic [TDATA_W-1:0] word);
    logic [ALPHA_W-1:0] resid;
    logic [ALPHA_W-1:0] above;
    logic [ALPHA_W-1:0] pred;
    logic [ALPHA_W-1:0] alpha;
    logic [RGB_W-1:0]   rgb;
    int unsigned        w_eff;
    int unsigned        h_eff;
    int unsigned        slot;
    int                 grad;
    logic               last;
    resid = word[ALPHA_W-1:0];
    rgb   = word[TDATA_W-1:ALPHA_W];
    w_eff = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h_eff = (height_reg == 0) ? 1 : height_reg;
    slot  = (col_pos < MAX_WIDTH) ? col_pos : MAX_WIDTH - 1;
    above = alpha_line[slot];
    if (mode_reg == MODE_NONE || (col_pos == 0 && row_pos == 0)) begin
      pred = '0;
    end else if (row_pos == 0) begin
      pred = left_a;
    end else if (col_pos == 0) begin
      pred = above;
    end else begin
      case (mode_reg)
        MODE_HORIZONTAL: pred = left_a;
        MODE_VERTICAL:   pred = above;
        default: begin
          grad = int'(left_a) + int'(above) - int'(upleft_a);
          if (grad < 0) pred = '0;
          else if (grad > ALPHA_MAX) pred = '1;
          else pred = grad[ALPHA_W-1:0];
        end
      endcase
    end
    alpha            = resid + pred;
    upleft_a         = above;
    alpha_line[slot] = alpha;
    left_a           = alpha;
    last = (col_pos + 1 >= w_eff) && (row_pos + 1 >= h_eff);
    if (col_pos + 1 >= w_eff) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h_eff) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    if (last) begin
      left_a   = '0;
      upleft_a = '0;
    end
    argb_expect.push_back('{argb: {alpha, rgb}, last: last});
  endfunction

  // one apb transfer: setup then access, reads are checked against the copy
  task automatic cfg_access(input logic [PADDR_W-1:0] addr, input logic wr,
                            input logic [PDATA_W-1:0] data);
    logic [PDATA_W-1:0] want;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (wr) begin
      case (addr[PADDR_W-1:2])
        REG_WIDTH: begin
          width_reg = data[CFG_WIDTH_W-1:0];
          restart_scan();
        end
        REG_HEIGHT: begin
          height_reg = data[CFG_HEIGHT_W-1:0];
          restart_scan();
        end
        REG_MODE: begin
          mode_reg = filter_mode_e'(data[1:0]);
          restart_scan();
        end
        default: ;
      endcase
    end else begin
      case (addr[PADDR_W-1:2])
        REG_WIDTH:  want = PDATA_W'(width_reg);
        REG_HEIGHT: want = PDATA_W'(height_reg);
        default:    want = PDATA_W'(mode_reg);
      endcase
      if (prdata !== want)
        flag_mismatch($sformatf("register at %h reads %h, wanted %h", addr, prdata, want));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_reg(input cfg_reg_e idx, input logic [PDATA_W-1:0] value);
    cfg_access({idx, 2'b00}, 1'b1, value);
    cfg_access({idx, 2'b00}, 1'b0, '0);
  endtask

  task automatic apply_setup(input logic [PDATA_W-1:0] wv, input logic [PDATA_W-1:0] hv,
                             input logic [PDATA_W-1:0] mv);
    set_reg(REG_WIDTH, wv);
    set_reg(REG_HEIGHT, hv);
    set_reg(REG_MODE, mv);
  endtask

  // wait until every queued word went through, then let the pipeline empty
  task automatic settle();
    while (pixel_fifo.size() != 0 || argb_expect.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic void queue_pixel(input logic [ALPHA_W-1:0] alpha,
                                      input logic [RGB_W-1:0] rgb);
    pixel_fifo.push_back({rgb, alpha});
  endfunction

  function automatic void feed(input int n);
    logic [ALPHA_W-1:0] alpha;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0:       alpha = '0;
        1:       alpha = '1;
        default: alpha = $urandom();
      endcase
      queue_pixel(alpha, $urandom());
    end
  endfunction

  // sender: bursts of random length with random gaps in between
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        unfilter_pixel(pixel_fifo.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 3))
            0:       gap_left = $urandom_range(8, 30);
            1:       gap_left = $urandom_range(1, 4);
            default: gap_left = 0;
          endcase
        end
      end else if (!s_axis_tvalid_i && gap_left > 0) begin
        gap_left--;
      end
      if (pixel_fifo.size() != 0 && gap_left == 0) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= pixel_fifo[0];
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // receiver: check each word, then pick ready from the current stall style
  int rdy_span  = 0;
  int rdy_style = 0;
  int rdy_hold  = 0;

  always @(posedge clk_i) begin
    pixel_out_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (argb_expect.size() == 0) begin
        flag_mismatch($sformatf("unexpected word %h", m_axis_tdata_o));
      end else begin
        want = argb_expect.pop_front();
        if (m_axis_tdata_o !== want.argb)
          flag_mismatch($sformatf("word %0d: argb %h, wanted %h",
                                  out_count, m_axis_tdata_o, want.argb));
        if (m_axis_tlast_o !== want.last)
          flag_mismatch($sformatf("word %0d: tlast %b, wanted %b",
                                  out_count, m_axis_tlast_o, want.last));
      end
      out_count++;
    end
    if (rdy_span == 0) begin
      rdy_style = $urandom_range(0, 3);
      rdy_span  = $urandom_range(16, 160);
    end else begin
      rdy_span--;
    end
    case (rdy_style)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= $urandom_range(0, 1);
      2: begin
        // mostly ready with a long stall now and then
        if (rdy_hold > 0) rdy_hold--;
        else if ($urandom_range(0, 15) == 0) rdy_hold = $urandom_range(5, 20);
        m_axis_tready_i <= (rdy_hold == 0);
      end
      default: m_axis_tready_i <= (rdy_span % 3 != 0);
    endcase
  end

  // watchdog on cycles without any handshake
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || psel || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    int          rand_items;
    int          n;
    int          pix;
    int          split;
    int unsigned wv;
    int unsigned hv;
    int unsigned w_eff;
    int unsigned h_eff;
    rand_items = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values of the registers
    cfg_access({REG_WIDTH, 2'b00}, 1'b0, '0);
    cfg_access({REG_HEIGHT, 2'b00}, 1'b0, '0);
    cfg_access({REG_MODE, 2'b00}, 1'b0, '0);

    // gradient on a 3x2 image: clip high at (1,1), clip low at (2,1), wrap
    apply_setup(3, 2, MODE_GRADIENT);
    queue_pixel(8'd0, '0);
    queue_pixel(8'd255, '1);
    queue_pixel(8'd1, $urandom());
    queue_pixel(8'd10, $urandom());
    queue_pixel(8'd11, $urandom());
    queue_pixel(8'd77, $urandom());
    queue_pixel(8'd128, '1);
    queue_pixel(8'd3, '0);
    settle();

    // horizontal, column 0 of row 1 takes the pixel above
    apply_setup(2, 2, MODE_HORIZONTAL);
    queue_pixel(8'd255, $urandom());
    queue_pixel(8'd255, $urandom());
    queue_pixel(8'd1, $urandom());
    queue_pixel(8'd254, $urandom());
    queue_pixel(8'd7, $urandom());
    settle();

    // vertical, row 0 takes the left pixel
    apply_setup(2, 3, MODE_VERTICAL);
    queue_pixel(8'd200, $urandom());
    queue_pixel(8'd100, $urandom());
    queue_pixel(8'd60, $urandom());
    queue_pixel(8'd255, $urandom());
    queue_pixel(8'd0, $urandom());
    queue_pixel(8'd9, $urandom());
    settle();

    // zero width and height act as one, every pixel ends an image
    apply_setup(0, 0, MODE_NONE);
    queue_pixel(8'd255, '1);
    queue_pixel(8'd0, '0);
    queue_pixel(8'd90, $urandom());
    settle();

    // oversized width clamps to the line buffer, no wrap in the first pixels
    apply_setup('1, 2, MODE_GRADIENT);
    feed(CLAMP_RUN);
    settle();

    // random images, mostly complete ones with some cut short
    while (rand_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 15))
        0:       wv = 0;
        1:       wv = $urandom_range(13, 70);
        default: wv = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 15))
        0:       hv = 0;
        1:       hv = $urandom_range(0, 1) ? HEIGHT_MAX : (1 << CFG_HEIGHT_W) - 1;
        default: hv = $urandom_range(1, 6);
      endcase
      w_eff = (wv == 0) ? 1 : wv;
      h_eff = (hv == 0) ? 1 : hv;
      pix   = (h_eff > 64) ? w_eff * $urandom_range(1, 3) : w_eff * h_eff;
      if ($urandom_range(0, 3) == 0) n = $urandom_range(1, pix);
      else n = pix * $urandom_range(1, 3);
      if (n > PHASE_CAP) n = PHASE_CAP;
      // junk above the register fields must be dropped
      if ($urandom_range(0, 3) == 0) wv = wv | ($urandom() << CFG_WIDTH_W);
      if ($urandom_range(0, 3) == 0) hv = hv | ($urandom() << CFG_HEIGHT_W);
      apply_setup(wv, hv, $urandom_range(MODE_NONE, MODE_GRADIENT) | ($urandom() << 2));
      rand_items += n;
      split = $urandom_range(0, n);
      case ($urandom_range(0, 5))
        0: begin
          // a write to the spare address keeps the scan going
          feed(split);
          settle();
          cfg_access(SPARE_ADDR, 1'b1, $urandom());
          feed(n - split);
        end
        1: begin
          // a mode write in mid image restarts the scan
          feed(split);
          settle();
          set_reg(REG_MODE, $urandom_range(MODE_NONE, MODE_GRADIENT));
          feed(n - split);
        end
        default: feed(n);
      endcase
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0 && argb_expect.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
